### design/dga_pkg.sv
// Shared constants, types and functions of the DNA global alignment block.
package dga_pkg;
	localparam int MaxLen = 32;
	localparam int RowLen = MaxLen + 1;
	localparam int LenW = $clog2(MaxLen + 1);
	localparam int SeqAw = $clog2(MaxLen);
	localparam int MatDepth = RowLen * RowLen;
	localparam int MatAw = $clog2(MatDepth);
	localparam int ColDepth = 2 * MaxLen;
	localparam int ColAw = $clog2(ColDepth);
	localparam int ColPosW = $clog2(ColDepth + 1);
	localparam int CostW = 10;
	localparam int ScoreW = 24;
	localparam int TotalW = 16;
	localparam int SymW = 3;
	localparam int PaddrW = 5;

	localparam logic [1:0] ActAppendFirst = 2'd0;
	localparam logic [1:0] ActAppendSecond = 2'd1;
	localparam logic [1:0] ActAlign = 2'd2;
	localparam logic [1:0] ActUnused = 2'd3;
	localparam logic [SymW-1:0] GapSymbol = 3'd4;

	localparam logic [2:0] RegGap = 3'd0;
	localparam logic [2:0] RegAc = 3'd1;
	localparam logic [2:0] RegAg = 3'd2;
	localparam logic [2:0] RegAt = 3'd3;
	localparam logic [2:0] RegCg = 3'd4;
	localparam logic [2:0] RegCt = 3'd5;
	localparam logic [2:0] RegGt = 3'd6;

	typedef struct packed {
		logic [CostW-1:0] gap;
		logic [CostW-1:0] ac;
		logic [CostW-1:0] ag;
		logic [CostW-1:0] at;
		logic [CostW-1:0] cg;
		logic [CostW-1:0] ct;
		logic [CostW-1:0] gt;
	} cost_cfg_t;

	function automatic logic [CostW-1:0] pair_cost(input logic [1:0] a, input logic [1:0] b,
			input cost_cfg_t c);
		logic [3:0] k;
		logic [CostW-1:0] r;
		k = (a < b) ? {a, b} : {b, a};
		case (k)
			4'b0001: r = c.ac;
			4'b0010: r = c.ag;
			4'b0011: r = c.at;
			4'b0110: r = c.cg;
			4'b0111: r = c.ct;
			4'b1011: r = c.gt;
			default: r = '0;
		endcase
		return r;
	endfunction
endpackage

### design/dna_global_alignment.sv
// Top level of the DNA global alignment block: sequencer, memories and output port.
// Append, unused and empty align requests leave the sequencer idle and can follow back to back.
// An align request writes the edges, then for each inner cell reads the diagonal, up and
// left cells through the single read port of the score memory and writes the result; it then
// reads the total, traces back column by column and emits the columns, which out_ready can stall.
// One request is worked on at a time; in_ready is low meanwhile. Reset clears the lengths,
// the registers and the sequencer; memories are not cleared.
module dna_global_alignment (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 action,
	input  logic [1:0]                 base,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [2:0]                 top_symbol,
	output logic [2:0]                 bottom_symbol,
	output logic [15:0]                total_cost,
	output logic                       last,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [dga_pkg::PaddrW-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import dga_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_EDGE, S_RD_D, S_RD_U, S_RD_L, S_CALC,
		S_TOTAL, S_TB_RD, S_TB_D, S_TB_U, S_TB_DEC, S_EMIT_RD, S_EMIT
	} state_t;

	state_t state_q;
	cost_cfg_t cfg;
	logic [LenW-1:0] m_q, n_q, i_q, j_q;
	logic [ColPosW-1:0] pos_q, k_q;
	logic [ScoreW-1:0] dia_q, up_q, here_q;
	logic [TotalW-1:0] total_q;
	logic [1:0] a_q, b_q;

	assign pready = 1'b1;

	dga_regs u_regs (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .cfg(cfg)
	);

	// Sequence stores: written by appends, read at i-1 and j-1.
	logic fs_we, ss_we;
	logic [SeqAw-1:0] fs_ra, ss_ra;
	logic [1:0] fs_rd, ss_rd;
	logic in_acc;
	assign in_acc = in_valid && in_ready;
	assign fs_we = in_acc && action == ActAppendFirst && m_q < LenW'(MaxLen);
	assign ss_we = in_acc && action == ActAppendSecond && n_q < LenW'(MaxLen);

	dga_ram #(.Width(2), .Depth(MaxLen)) u_first (
		.clk(clk), .we(fs_we), .waddr(m_q[SeqAw-1:0]), .wdata(base),
		.raddr(fs_ra), .rdata(fs_rd)
	);
	dga_ram #(.Width(2), .Depth(MaxLen)) u_second (
		.clk(clk), .we(ss_we), .waddr(n_q[SeqAw-1:0]), .wdata(base),
		.raddr(ss_ra), .rdata(ss_rd)
	);

	// i-1 and j-1 as sequence addresses (only used where i, j >= 1).
	logic [LenW-1:0] im1, jm1;
	assign im1 = i_q - 1'b1;
	assign jm1 = j_q - 1'b1;
	assign fs_ra = im1[SeqAw-1:0];
	assign ss_ra = jm1[SeqAw-1:0];

	// Score memory, one read and one write port, address i*RowLen+j.
	logic mx_we;
	logic [MatAw-1:0] mx_wa, mx_ra;
	logic [ScoreW-1:0] mx_wd, mx_rd;
	dga_ram #(.Width(ScoreW), .Depth(MatDepth)) u_matrix (
		.clk(clk), .we(mx_we), .waddr(mx_wa), .wdata(mx_wd), .raddr(mx_ra), .rdata(mx_rd)
	);

	function automatic logic [MatAw-1:0] maddr(input logic [LenW-1:0] i, input logic [LenW-1:0] j);
		return MatAw'(i * RowLen) + MatAw'(j);
	endfunction

	// Column buffer: top and bottom symbol of each aligned column.
	logic cb_we;
	logic [ColAw-1:0] cb_wa, cb_ra;
	logic [5:0] cb_wd, cb_rd;
	dga_ram #(.Width(6), .Depth(ColDepth)) u_cols (
		.clk(clk), .we(cb_we), .waddr(cb_wa), .wdata(cb_wd), .raddr(cb_ra), .rdata(cb_rd)
	);
	logic [ColPosW-1:0] posm1;
	assign posm1 = pos_q - 1'b1;
	assign cb_ra = k_q[ColAw-1:0];

	// Cell arithmetic. The value just read plus the gap is the left term while
	// filling and the up term during traceback.
	logic [ScoreW-1:0] gap_x, mis, best_c, edge_v, dsum, usum, rsum;
	assign gap_x = ScoreW'(cfg.gap);
	assign mis = ScoreW'(pair_cost(a_q, b_q, cfg));
	assign dsum = dia_q + mis;
	assign usum = up_q + gap_x;
	assign rsum = mx_rd + gap_x;
	always_comb begin
		best_c = dsum;
		if (usum < best_c) best_c = usum;
		if (rsum < best_c) best_c = rsum;
		if (a_q == b_q) best_c = dia_q;
	end
	// Edge value = gap * (i or j), i.e. gap times the nonzero index.
	assign edge_v = gap_x * ScoreW'((i_q == '0) ? j_q : i_q);

	// Memory ports and the traceback decision, taken once the up cell is read.
	logic tb_i, tb_j, tb_done;
	always_comb begin
		mx_we = 1'b0;
		mx_wa = maddr(i_q, j_q);
		mx_wd = best_c;
		mx_ra = maddr(i_q, j_q);
		cb_we = 1'b0;
		cb_wa = posm1[ColAw-1:0];
		cb_wd = {GapSymbol, GapSymbol};
		tb_i = 1'b0;
		tb_j = 1'b0;
		case (state_q)
			S_EDGE: begin
				mx_we = 1'b1;
				mx_wd = edge_v;
			end
			S_RD_D: mx_ra = maddr(im1, jm1);
			S_RD_U: mx_ra = maddr(im1, j_q);
			S_RD_L: mx_ra = maddr(i_q, jm1);
			S_CALC: mx_we = 1'b1;
			S_TB_RD: mx_ra = maddr(i_q, j_q);
			S_TB_D: mx_ra = maddr(im1, jm1);
			S_TB_U: mx_ra = maddr(im1, j_q);
			S_TB_DEC: begin
				cb_we = 1'b1;
				if (j_q == '0) begin
					cb_wd = {1'b0, a_q, GapSymbol};
					tb_i = 1'b1;
				end else if (i_q == '0) begin
					cb_wd = {GapSymbol, 1'b0, b_q};
					tb_j = 1'b1;
				end else if (a_q == b_q || here_q == dsum) begin
					cb_wd = {1'b0, a_q, 1'b0, b_q};
					tb_i = 1'b1;
					tb_j = 1'b1;
				end else if (here_q == rsum) begin
					cb_wd = {1'b0, a_q, GapSymbol};
					tb_i = 1'b1;
				end else begin
					cb_wd = {GapSymbol, 1'b0, b_q};
					tb_j = 1'b1;
				end
			end
			default: ;
		endcase
	end
	assign tb_done = ((tb_i ? im1 : i_q) == '0) && ((tb_j ? jm1 : j_q) == '0);

	logic col_last;
	assign col_last = (k_q + 1'b1) == (ColPosW'(m_q) + ColPosW'(n_q));

	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			m_q <= '0;
			n_q <= '0;
			i_q <= '0;
			j_q <= '0;
			pos_q <= '0;
			k_q <= '0;
			dia_q <= '0;
			up_q <= '0;
			here_q <= '0;
			total_q <= '0;
			a_q <= '0;
			b_q <= '0;
			out_valid <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_acc) begin
					if (fs_we) m_q <= m_q + 1'b1;
					if (ss_we) n_q <= n_q + 1'b1;
					if (action == ActAlign && (m_q != '0 || n_q != '0)) begin
						i_q <= '0;
						j_q <= '0;
						state_q <= S_EDGE;
					end
				end
				// Row 0 then column 0 are written with multiples of the gap cost.
				S_EDGE: begin
					if (i_q == '0 && j_q != n_q) j_q <= j_q + 1'b1;
					else if (i_q == '0) begin
						j_q <= '0;
						i_q <= (m_q == '0) ? '0 : LenW'(1);
						if (m_q == '0) begin
							i_q <= m_q;
							j_q <= n_q;
							state_q <= S_TOTAL;
						end
					end else if (i_q != m_q) i_q <= i_q + 1'b1;
					else if (n_q == '0) begin
						j_q <= n_q;
						state_q <= S_TOTAL;
					end else begin
						i_q <= LenW'(1);
						j_q <= LenW'(1);
						state_q <= S_RD_D;
					end
				end
				S_RD_D: state_q <= S_RD_U;
				S_RD_U: begin
					dia_q <= mx_rd;
					a_q <= fs_rd;
					b_q <= ss_rd;
					state_q <= S_RD_L;
				end
				S_RD_L: begin
					up_q <= mx_rd;
					state_q <= S_CALC;
				end
				S_CALC: begin
					if (j_q != n_q) begin
						j_q <= j_q + 1'b1;
						state_q <= S_RD_D;
					end else if (i_q != m_q) begin
						i_q <= i_q + 1'b1;
						j_q <= LenW'(1);
						state_q <= S_RD_D;
					end else begin
						state_q <= S_TOTAL;
					end
				end
				// Read the final cell; i, j sit at m, n.
				S_TOTAL: begin
					pos_q <= ColPosW'(m_q) + ColPosW'(n_q);
					state_q <= S_TB_RD;
				end
				// On the first step the final cell read above is on the bus.
				S_TB_RD: begin
					if (pos_q == ColPosW'(m_q) + ColPosW'(n_q)) begin
						total_q <= (mx_rd > ScoreW'(16'hFFFF)) ? 16'hFFFF : mx_rd[TotalW-1:0];
					end
					state_q <= S_TB_D;
				end
				S_TB_D: begin
					here_q <= mx_rd;
					a_q <= fs_rd;
					b_q <= ss_rd;
					state_q <= S_TB_U;
				end
				S_TB_U: begin
					dia_q <= mx_rd;
					state_q <= S_TB_DEC;
				end
				// The up cell is on the bus; write the column and step back.
				S_TB_DEC: begin
					pos_q <= posm1;
					if (tb_i) i_q <= im1;
					if (tb_j) j_q <= jm1;
					if (tb_done) begin
						k_q <= posm1;
						state_q <= S_EMIT_RD;
					end else state_q <= S_TB_RD;
				end
				S_EMIT_RD: begin
					out_valid <= 1'b1;
					state_q <= S_EMIT;
				end
				S_EMIT: if (out_ready) begin
					out_valid <= 1'b0;
					if (col_last) state_q <= S_IDLE;
					else begin
						k_q <= k_q + 1'b1;
						state_q <= S_EMIT_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign top_symbol = cb_rd[5:3];
	assign bottom_symbol = cb_rd[2:0];
	assign total_cost = total_q;
	assign last = col_last;

	a_len_first: assert property (@(posedge clk) disable iff (!arst_n)
		m_q <= LenW'(MaxLen)) else $error("first length overflow");
	a_len_second: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= LenW'(MaxLen)) else $error("second length overflow");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("output offered while idle");
	a_lens_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |=> $stable(m_q) && $stable(n_q)) else $error("lengths moved");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid &&
		$stable({top_symbol, bottom_symbol, total_cost, last})) else $error("output dropped");
endmodule

### design/dga_ram.sv
// Generic single-port-write, one-read synchronous RAM with registered read.
module dga_ram #(
	parameter int Width = 8,
	parameter int Depth = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### design/dga_regs.sv
// APB configuration registers holding the gap and mismatch costs.
module dga_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [dga_pkg::PaddrW-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output dga_pkg::cost_cfg_t        cfg
);
	import dga_pkg::*;

	logic [2:0] idx;
	assign idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.gap <= 10'd30;
			cfg.ac <= 10'd110;
			cfg.ag <= 10'd48;
			cfg.at <= 10'd94;
			cfg.cg <= 10'd118;
			cfg.ct <= 10'd48;
			cfg.gt <= 10'd110;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				RegGap: cfg.gap <= pwdata[CostW-1:0];
				RegAc: cfg.ac <= pwdata[CostW-1:0];
				RegAg: cfg.ag <= pwdata[CostW-1:0];
				RegAt: cfg.at <= pwdata[CostW-1:0];
				RegCg: cfg.cg <= pwdata[CostW-1:0];
				RegCt: cfg.ct <= pwdata[CostW-1:0];
				RegGt: cfg.gt <= pwdata[CostW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			RegGap: prdata[CostW-1:0] = cfg.gap;
			RegAc: prdata[CostW-1:0] = cfg.ac;
			RegAg: prdata[CostW-1:0] = cfg.ag;
			RegAt: prdata[CostW-1:0] = cfg.at;
			RegCg: prdata[CostW-1:0] = cfg.cg;
			RegCt: prdata[CostW-1:0] = cfg.ct;
			RegGt: prdata[CostW-1:0] = cfg.gt;
			default: prdata = '0;
		endcase
	end
endmodule
